// ===== hw/rtl/ddwg_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual DAC wave generator package
// Shared widths, register offsets, field codes and types.
// ----------------------------------------------------------------------------
package ddwg_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int LEVEL_BITS     = SAMPLE_BITS + 1;
    localparam int LEFT_SHIFT     = 16 - SAMPLE_BITS;
    localparam int AMP_BITS       = 4;
    localparam int WAVE_BITS      = 2;
    localparam int OFFSET_BITS    = 10;
    localparam int WORD_BITS      = 32;
    localparam int HOLD_COUNT     = 9;
    localparam int HOLD_IDX_BITS  = $clog2(HOLD_COUNT);
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = AMP_BITS;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LEVEL_BITS-1:0]  level_t;
    typedef logic [AMP_BITS-1:0]    amp_t;
    typedef logic [WAVE_BITS-1:0]   wave_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [WORD_BITS-1:0]   word_t;

    localparam sample_t SAMPLE_MASK = '1;
    localparam sample_t NOISE_RESET = SAMPLE_BITS'(12'hAAA);
    localparam amp_t    AMP_MAX     = AMP_BITS'(SAMPLE_BITS - 1);

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam wave_t WAVE_NONE  = 2'd0;
    localparam wave_t WAVE_NOISE = 2'd1;
    localparam wave_t WAVE_TRI   = 2'd2;

    localparam offset_t OFF_CTRL       = 10'h000;
    localparam offset_t OFF_TRIG       = 10'h004;
    localparam offset_t OFF_HOLD_FIRST = 10'h008;
    localparam offset_t OFF_HOLD_LAST  = 10'h028;
    localparam offset_t OFF_OUT_A      = 10'h02C;
    localparam offset_t OFF_OUT_B      = 10'h030;

    localparam int CTRL_TEN_A_BIT = 2;
    localparam int CTRL_WAVE_A_LO = 6;
    localparam int CTRL_AMP_A_LO  = 8;
    localparam int CTRL_TEN_B_BIT = 18;
    localparam int CTRL_WAVE_B_LO = 22;
    localparam int CTRL_AMP_B_LO  = 24;

    typedef enum logic [HOLD_IDX_BITS-1:0] {
        HOLD_12R_A,
        HOLD_12L_A,
        HOLD_8R_A,
        HOLD_12R_B,
        HOLD_12L_B,
        HOLD_8R_B,
        HOLD_12R_D,
        HOLD_12L_D,
        HOLD_8R_D
    } hold_sel_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TEN_A,
        CFG_WAVE_A,
        CFG_AMP_A,
        CFG_TEN_B,
        CFG_WAVE_B,
        CFG_AMP_B
    } cfg_sel_t;

    typedef struct packed {
        sample_t count;
        logic    rising;
    } tri_t;

endpackage

// ===== hw/rtl/ddwg_req_if.sv =====
// ----------------------------------------------------------------------------
// Bus access channel
// Valid/ready channel carrying one register read or write.
// ----------------------------------------------------------------------------
interface ddwg_req_if;

    logic              valid;
    logic              ready;
    logic              action;
    ddwg_pkg::offset_t reg_offset;
    ddwg_pkg::word_t   write_data;

    modport source (
        output valid,
        output action,
        output reg_offset,
        output write_data,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  reg_offset,
        input  write_data,
        output ready
    );

endinterface

// ===== hw/rtl/ddwg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Access result channel
// Valid/ready channel carrying read data, error flag and both DAC levels.
// ----------------------------------------------------------------------------
interface ddwg_rsp_if;

    logic             valid;
    logic             ready;
    ddwg_pkg::word_t  read_data;
    logic             bad_access;
    ddwg_pkg::level_t level_a;
    ddwg_pkg::level_t level_b;

    modport source (
        output valid,
        output read_data,
        output bad_access,
        output level_a,
        output level_b,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_data,
        input  bad_access,
        input  level_a,
        input  level_b,
        output ready
    );

endinterface

// ===== hw/rtl/dual_dac_wave_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Dual DAC wave generator
// Two-channel DAC register block with triangle and noise wave generation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one bus access (action, reg_offset, write_data); rsp returns
//   read_data, bad_access and the two output levels after that access.
//   Each access is decoded and applied in the cycle it is accepted; the
//   result register holds its response, visible in the cycle after the
//   transfer. Throughput is one access per cycle while rsp.ready stays
//   high, set by the single result register.
//   req.ready is high while the result register is empty or being taken,
//   so a stalled receiver stops new transfers only once a result waits.
//   The cfg_wr_en/cfg_index/cfg_wr_data port writes the channel trigger
//   enable, wave mode and amplitude fields, with no wait.
//   rst_n clears all registers at once but the result data and error
//   flag: holding words, data and outputs to zero, noise register to
//   0xAAA, triangle counters at zero counting up, no result pending.
// ----------------------------------------------------------------------------
module dual_dac_wave_generator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ddwg_req_if.sink                               req,
    ddwg_rsp_if.source                             rsp,
    input  logic                                   cfg_wr_en,
    input  logic [ddwg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ddwg_pkg::CFG_DATA_BITS-1:0]     cfg_wr_data
);

    logic                ten_a_reg, ten_a_next;
    logic                ten_b_reg, ten_b_next;
    ddwg_pkg::wave_t     wave_a_reg, wave_a_next;
    ddwg_pkg::wave_t     wave_b_reg, wave_b_next;
    ddwg_pkg::amp_t      amp_a_reg, amp_a_next;
    ddwg_pkg::amp_t      amp_b_reg, amp_b_next;

    ddwg_pkg::word_t     hold_reg [ddwg_pkg::HOLD_COUNT];
    ddwg_pkg::sample_t   data_a_reg, data_a_next;
    ddwg_pkg::sample_t   data_b_reg, data_b_next;
    ddwg_pkg::level_t    out_a_reg, out_a_next;
    ddwg_pkg::level_t    out_b_reg, out_b_next;
    logic [1:0]          soft_reg, soft_next;
    ddwg_pkg::sample_t   noise_reg, noise_next;
    ddwg_pkg::tri_t      tri_a_reg, tri_a_next;
    ddwg_pkg::tri_t      tri_b_reg, tri_b_next;

    logic                rsp_valid_reg;
    ddwg_pkg::word_t     rsp_data_reg, rsp_data_next;
    logic                rsp_bad_reg, rsp_bad_next;

    logic                acc;
    logic                is_wr;
    ddwg_pkg::offset_t   off;
    ddwg_pkg::word_t     val;
    ddwg_pkg::offset_t   hold_rel;
    logic                hold_hit;
    logic [ddwg_pkg::HOLD_IDX_BITS-1:0] hold_idx;
    ddwg_pkg::hold_sel_t hold_sel;

    ddwg_pkg::amp_t      amp_a_c, amp_b_c;
    ddwg_pkg::sample_t   mask_a, mask_b;
    logic                fire_a, fire_b;
    logic                tri_on_a, tri_on_b;
    logic                noise_on_a, noise_on_b;
    ddwg_pkg::sample_t   add_a, add_b;
    ddwg_pkg::word_t     ctrl_word;

    logic                set_a, set_b;
    ddwg_pkg::sample_t   set_a_val, set_b_val;

    function automatic ddwg_pkg::sample_t noise_step(input ddwg_pkg::sample_t v);
        logic chain;
        logic fb;
        chain = v[0];
        for (int i = 1; i < ddwg_pkg::SAMPLE_BITS; i++)
        begin
            chain = ~(chain | v[i]);
        end
        fb = v[0] ^ v[1] ^ v[4] ^ v[6] ^ chain;
        return {fb, v[ddwg_pkg::SAMPLE_BITS-1:1]};
    endfunction

    function automatic ddwg_pkg::tri_t tri_step(input ddwg_pkg::tri_t t,
                                                input ddwg_pkg::sample_t peak);
        ddwg_pkg::tri_t r;
        r.rising = t.rising;
        r.count  = t.rising ? t.count + 1'b1 : t.count - 1'b1;
        if (r.count >= peak)
        begin
            r.rising = 1'b0;
        end
        if (r.count == '0)
        begin
            r.rising = 1'b1;
        end
        return r;
    endfunction

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign acc       = req.valid && req.ready;
    assign is_wr     = (req.action == ddwg_pkg::ACT_WRITE);
    assign off       = req.reg_offset;
    assign val       = req.write_data;

    assign hold_rel  = off - ddwg_pkg::OFF_HOLD_FIRST;
    assign hold_hit  = (off >= ddwg_pkg::OFF_HOLD_FIRST) && (off <= ddwg_pkg::OFF_HOLD_LAST)
                       && (off[1:0] == 2'b00);
    assign hold_idx  = hold_rel[ddwg_pkg::HOLD_IDX_BITS+1:2];
    assign hold_sel  = ddwg_pkg::hold_sel_t'(hold_idx);

    assign amp_a_c   = (amp_a_reg > ddwg_pkg::AMP_MAX) ? ddwg_pkg::AMP_MAX : amp_a_reg;
    assign amp_b_c   = (amp_b_reg > ddwg_pkg::AMP_MAX) ? ddwg_pkg::AMP_MAX : amp_b_reg;
    assign mask_a    = ddwg_pkg::SAMPLE_MASK >> (ddwg_pkg::AMP_MAX - amp_a_c);
    assign mask_b    = ddwg_pkg::SAMPLE_MASK >> (ddwg_pkg::AMP_MAX - amp_b_c);

    assign fire_a     = val[0] && ten_a_reg;
    assign fire_b     = val[1] && ten_b_reg;
    assign tri_on_a   = fire_a && (wave_a_reg >= ddwg_pkg::WAVE_TRI);
    assign tri_on_b   = fire_b && (wave_b_reg >= ddwg_pkg::WAVE_TRI);
    assign noise_on_a = fire_a && (wave_a_reg == ddwg_pkg::WAVE_NOISE);
    assign noise_on_b = fire_b && (wave_b_reg == ddwg_pkg::WAVE_NOISE);
    assign add_a      = tri_on_a   ? tri_a_reg.count :
                        noise_on_a ? (noise_reg & mask_a) : '0;
    assign add_b      = tri_on_b   ? tri_b_reg.count :
                        noise_on_b ? (noise_reg & mask_b) : '0;

    always_comb
    begin
        ctrl_word = '0;
        ctrl_word[ddwg_pkg::CTRL_TEN_A_BIT] = ten_a_reg;
        ctrl_word[ddwg_pkg::CTRL_WAVE_A_LO +: ddwg_pkg::WAVE_BITS] = wave_a_reg;
        ctrl_word[ddwg_pkg::CTRL_AMP_A_LO +: ddwg_pkg::AMP_BITS] = amp_a_reg;
        ctrl_word[ddwg_pkg::CTRL_TEN_B_BIT] = ten_b_reg;
        ctrl_word[ddwg_pkg::CTRL_WAVE_B_LO +: ddwg_pkg::WAVE_BITS] = wave_b_reg;
        ctrl_word[ddwg_pkg::CTRL_AMP_B_LO +: ddwg_pkg::AMP_BITS] = amp_b_reg;
    end

    // Decode holding register writes into per-channel data loads.
    always_comb
    begin
        set_a     = 1'b0;
        set_b     = 1'b0;
        set_a_val = val[ddwg_pkg::SAMPLE_BITS-1:0];
        set_b_val = val[ddwg_pkg::SAMPLE_BITS-1:0];
        case (hold_sel)
            ddwg_pkg::HOLD_12R_A:
            begin
                set_a = 1'b1;
            end
            ddwg_pkg::HOLD_12L_A:
            begin
                set_a     = 1'b1;
                set_a_val = val[ddwg_pkg::LEFT_SHIFT +: ddwg_pkg::SAMPLE_BITS];
            end
            ddwg_pkg::HOLD_8R_A:
            begin
                set_a     = 1'b1;
                set_a_val = ddwg_pkg::SAMPLE_BITS'(val[7:0]);
            end
            ddwg_pkg::HOLD_12R_B:
            begin
                set_b = 1'b1;
            end
            ddwg_pkg::HOLD_12L_B:
            begin
                set_b     = 1'b1;
                set_b_val = val[ddwg_pkg::LEFT_SHIFT +: ddwg_pkg::SAMPLE_BITS];
            end
            ddwg_pkg::HOLD_8R_B:
            begin
                set_b     = 1'b1;
                set_b_val = ddwg_pkg::SAMPLE_BITS'(val[7:0]);
            end
            ddwg_pkg::HOLD_12R_D:
            begin
                set_a     = 1'b1;
                set_b     = 1'b1;
                set_b_val = val[16 +: ddwg_pkg::SAMPLE_BITS];
            end
            ddwg_pkg::HOLD_12L_D:
            begin
                set_a     = 1'b1;
                set_b     = 1'b1;
                set_a_val = val[ddwg_pkg::LEFT_SHIFT +: ddwg_pkg::SAMPLE_BITS];
                set_b_val = val[16 + ddwg_pkg::LEFT_SHIFT +: ddwg_pkg::SAMPLE_BITS];
            end
            ddwg_pkg::HOLD_8R_D:
            begin
                set_a     = 1'b1;
                set_b     = 1'b1;
                set_a_val = ddwg_pkg::SAMPLE_BITS'(val[7:0]);
                set_b_val = ddwg_pkg::SAMPLE_BITS'(val[15:8]);
            end
            default:
            begin
                set_a = 1'b0;
                set_b = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ten_a_next    = ten_a_reg;
        ten_b_next    = ten_b_reg;
        wave_a_next   = wave_a_reg;
        wave_b_next   = wave_b_reg;
        amp_a_next    = amp_a_reg;
        amp_b_next    = amp_b_reg;
        data_a_next   = data_a_reg;
        data_b_next   = data_b_reg;
        out_a_next    = out_a_reg;
        out_b_next    = out_b_reg;
        soft_next     = soft_reg;
        noise_next    = noise_reg;
        tri_a_next    = tri_a_reg;
        tri_b_next    = tri_b_reg;
        rsp_data_next = '0;
        rsp_bad_next  = 1'b0;

        if (cfg_wr_en)
        begin
            case (ddwg_pkg::cfg_sel_t'(cfg_index))
                ddwg_pkg::CFG_TEN_A:  ten_a_next  = cfg_wr_data[0];
                ddwg_pkg::CFG_WAVE_A: wave_a_next = cfg_wr_data[ddwg_pkg::WAVE_BITS-1:0];
                ddwg_pkg::CFG_AMP_A:  amp_a_next  = cfg_wr_data;
                ddwg_pkg::CFG_TEN_B:  ten_b_next  = cfg_wr_data[0];
                ddwg_pkg::CFG_WAVE_B: wave_b_next = cfg_wr_data[ddwg_pkg::WAVE_BITS-1:0];
                ddwg_pkg::CFG_AMP_B:  amp_b_next  = cfg_wr_data;
                default:              ten_a_next  = ten_a_reg;
            endcase
        end

        if (acc)
        begin
            if (hold_hit)
            begin
                if (is_wr)
                begin
                    if (set_a)
                    begin
                        data_a_next = set_a_val;
                        if (!ten_a_reg)
                        begin
                            out_a_next = {1'b0, set_a_val};
                        end
                    end
                    if (set_b)
                    begin
                        data_b_next = set_b_val;
                        if (!ten_b_reg)
                        begin
                            out_b_next = {1'b0, set_b_val};
                        end
                    end
                end
                else
                begin
                    rsp_data_next = hold_reg[hold_idx];
                end
            end
            else if (off == ddwg_pkg::OFF_CTRL)
            begin
                if (is_wr)
                begin
                    ten_a_next  = val[ddwg_pkg::CTRL_TEN_A_BIT];
                    wave_a_next = val[ddwg_pkg::CTRL_WAVE_A_LO +: ddwg_pkg::WAVE_BITS];
                    amp_a_next  = val[ddwg_pkg::CTRL_AMP_A_LO +: ddwg_pkg::AMP_BITS];
                    ten_b_next  = val[ddwg_pkg::CTRL_TEN_B_BIT];
                    wave_b_next = val[ddwg_pkg::CTRL_WAVE_B_LO +: ddwg_pkg::WAVE_BITS];
                    amp_b_next  = val[ddwg_pkg::CTRL_AMP_B_LO +: ddwg_pkg::AMP_BITS];
                end
                else
                begin
                    rsp_data_next = ctrl_word;
                end
            end
            else if (off == ddwg_pkg::OFF_TRIG)
            begin
                if (is_wr)
                begin
                    soft_next = val[1:0] & ~{fire_b, fire_a};
                    if (val[0])
                    begin
                        out_a_next = {1'b0, data_a_reg} + {1'b0, add_a};
                    end
                    if (val[1])
                    begin
                        out_b_next = {1'b0, data_b_reg} + {1'b0, add_b};
                    end
                    if (tri_on_a)
                    begin
                        tri_a_next = tri_step(tri_a_reg, mask_a);
                    end
                    if (tri_on_b)
                    begin
                        tri_b_next = tri_step(tri_b_reg, mask_b);
                    end
                    if (noise_on_a || noise_on_b)
                    begin
                        noise_next = noise_step(noise_reg);
                    end
                end
                else
                begin
                    rsp_data_next = ddwg_pkg::WORD_BITS'(soft_reg);
                end
            end
            else if ((off == ddwg_pkg::OFF_OUT_A) || (off == ddwg_pkg::OFF_OUT_B))
            begin
                if (is_wr)
                begin
                    rsp_bad_next = 1'b1;
                end
                else
                begin
                    rsp_data_next = (off == ddwg_pkg::OFF_OUT_A) ?
                                    ddwg_pkg::WORD_BITS'(out_a_reg) :
                                    ddwg_pkg::WORD_BITS'(out_b_reg);
                end
            end
            else
            begin
                rsp_bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ddwg_pkg::HOLD_COUNT; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else if (acc && is_wr && hold_hit)
        begin
            hold_reg[hold_idx] <= val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_a_reg     <= 1'b0;
            ten_b_reg     <= 1'b0;
            wave_a_reg    <= ddwg_pkg::WAVE_NONE;
            wave_b_reg    <= ddwg_pkg::WAVE_NONE;
            amp_a_reg     <= '0;
            amp_b_reg     <= '0;
            data_a_reg    <= '0;
            data_b_reg    <= '0;
            out_a_reg     <= '0;
            out_b_reg     <= '0;
            soft_reg      <= '0;
            noise_reg     <= ddwg_pkg::NOISE_RESET;
            tri_a_reg     <= '{count: '0, rising: 1'b1};
            tri_b_reg     <= '{count: '0, rising: 1'b1};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ten_a_reg     <= ten_a_next;
            ten_b_reg     <= ten_b_next;
            wave_a_reg    <= wave_a_next;
            wave_b_reg    <= wave_b_next;
            amp_a_reg     <= amp_a_next;
            amp_b_reg     <= amp_b_next;
            data_a_reg    <= data_a_next;
            data_b_reg    <= data_b_next;
            out_a_reg     <= out_a_next;
            out_b_reg     <= out_b_next;
            soft_reg      <= soft_next;
            noise_reg     <= noise_next;
            tri_a_reg     <= tri_a_next;
            tri_b_reg     <= tri_b_next;
            if (acc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rsp_data_reg <= rsp_data_next;
            rsp_bad_reg  <= rsp_bad_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = rsp_data_reg;
    assign rsp.bad_access = rsp_bad_reg;
    assign rsp.level_a    = out_a_reg;
    assign rsp.level_b    = out_b_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> rsp.valid)
        else $error("accepted access produced no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> req.ready)
        else $error("input stalled with empty result register");

    a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> ($stable(out_a_reg) && $stable(out_b_reg)))
        else $error("output level changed without an access");

    a_noise_only_on_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        !(acc && is_wr && (off == ddwg_pkg::OFF_TRIG)) |=> $stable(noise_reg))
        else $error("noise register advanced outside a trigger write");

    a_trigger_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_wr && (off == ddwg_pkg::OFF_TRIG) && val[0] && ten_a_reg)
        |=> !soft_reg[0])
        else $error("channel A trigger bit not cleared after firing");

endmodule
